FILE: src/dpe_pkg.sv
// Shared types and constants of the divisor pair enumerator.
package dpe_pkg;

  // Fixed field widths of the external beats and the trial divisor
  localparam int unsigned NUMBER_W   = 16;
  localparam int unsigned DIVISOR_W  = 8;
  localparam int unsigned COFACTOR_W = 16;
  localparam int unsigned TRIAL_W    = 9;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FLUSH
  } dpe_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new number, seed pending pair (1, n)
    logic div_start;  // launch a trial division
    logic found;      // trial divides: emit pending pair, keep the new one
    logic advance;    // step to the next trial divisor
    logic flush;      // emit pending pair with last set
  } dpe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cont;       // trial divisor still in range (d <= 255, d*d <= n)
    logic div_done;   // divider result valid this cycle
    logic rem_zero;   // remainder of the last division is zero
  } dpe_sts_t;

endpackage

FILE: src/divisor_pair_enumerator.sv
// Top level of the divisor pair enumerator.
//
// Usage: pulse start_i with number_i while busy_o is low; that beat is taken
// and busy_o rises on the next cycle. Only the low NUMBER_BITS bits count.
// The block lists every pair (d, number/d) with d dividing number and
// d*d <= number, d ascending, starting with d = 1. Each pair is one result
// beat on divisor_o/cofactor_o/last_o, marked by valid_o for one cycle; the
// final pair has last_o set, and busy_o is low in that same cycle.
// For odd numbers only odd trial divisors are tried.
// Each trial divisor takes a range check, a bit-serial division of one
// quotient bit per cycle in the single shared divider, and a done step.
// At most 254 trial divisors are tried for one number.
// A result beat leaves one pair late, so the first beat appears after the
// next divisor is found or at the end.
// The receiver cannot stall; beats are not held. Reset returns to idle and
// drops any number in progress.
module divisor_pair_enumerator #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dpe_pkg::NUMBER_W-1:0]    number_i,
  output logic                            busy_o,
  output logic                            valid_o,
  output logic [dpe_pkg::DIVISOR_W-1:0]   divisor_o,
  output logic [dpe_pkg::COFACTOR_W-1:0]  cofactor_o,
  output logic                            last_o
);
  import dpe_pkg::*;

  dpe_cmd_t cmd;
  dpe_sts_t sts;
  logic     busy;

  // Sequencer
  dpe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Datapath
  dpe_datapath #(
    .NB (NUMBER_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .number_i   (number_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .divisor_o  (divisor_o),
    .cofactor_o (cofactor_o),
    .last_o     (last_o)
  );

  assign busy_o = busy;

endmodule

FILE: src/dpe_divider.sv
// Restoring radix-2 divider: NB-bit dividend by 8-bit divisor, one bit per cycle.
module dpe_divider #(
  parameter int unsigned NB = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [NB-1:0]                  dividend_i,
  input  logic [dpe_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [NB-1:0]                  quotient_o,
  output logic                           rem_zero_o
);
  import dpe_pkg::*;

  localparam int unsigned CW = (NB > 1) ? $clog2(NB) : 1;

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [NB-1:0]        quo_q, quo_d;
  logic [CW-1:0]        cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[NB-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[NB-2:0], ge};
  end

  // Control: run flag, bit counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NB - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

FILE: src/dpe_ctrl.sv
// Controller state machine that sequences trial divisions and result beats.
module dpe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dpe_pkg::dpe_sts_t sts_i,
  output dpe_pkg::dpe_cmd_t cmd_o,
  output logic              busy_o
);
  import dpe_pkg::*;

  dpe_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.cont) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.advance = 1'b1;
          cmd_o.found   = sts_i.rem_zero;
          state_d       = ST_CHECK;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: src/dpe_datapath.sv
// Datapath: held number, trial divisor, range test, divider, pending pair, output beat.
module dpe_datapath #(
  parameter int unsigned NB = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [dpe_pkg::NUMBER_W-1:0]    number_i,
  input  dpe_pkg::dpe_cmd_t               cmd_i,
  output dpe_pkg::dpe_sts_t               sts_o,
  output logic                            valid_o,
  output logic [dpe_pkg::DIVISOR_W-1:0]   divisor_o,
  output logic [dpe_pkg::COFACTOR_W-1:0]  cofactor_o,
  output logic                            last_o
);
  import dpe_pkg::*;

  logic [NB-1:0]        num_q;
  logic [TRIAL_W-1:0]   trial_q;
  logic                 odd_q;
  logic [DIVISOR_W-1:0] pend_div_q;
  logic [NB-1:0]        pend_cof_q;
  logic [DIVISOR_W-1:0] out_div_q;
  logic [NB-1:0]        out_cof_q;
  logic                 out_last_q;
  logic                 out_valid_q;
  logic [NB-1:0]        number_masked;
  logic [2*DIVISOR_W-1:0] square;
  logic                 div_done;
  logic                 rem_zero;
  logic [NB-1:0]        quotient;

  assign number_masked = number_i[NB-1:0];

  // Range test on the current trial divisor
  assign square = trial_q[DIVISOR_W-1:0] * trial_q[DIVISOR_W-1:0];
  assign sts_o.cont = !trial_q[TRIAL_W-1] &&
                      (square <= (2*DIVISOR_W)'(num_q));
  assign sts_o.div_done = div_done;
  assign sts_o.rem_zero = rem_zero;

  // Shared trial divider
  dpe_divider #(
    .NB (NB)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (trial_q[DIVISOR_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quotient),
    .rem_zero_o (rem_zero)
  );

  // Number, trial divisor, pending pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      trial_q <= '0;
      odd_q   <= 1'b0;
    end else if (cmd_i.load) begin
      num_q   <= number_masked;
      odd_q   <= number_masked[0];
      trial_q <= number_masked[0] ? TRIAL_W'(3) : TRIAL_W'(2);
    end else if (cmd_i.advance) begin
      trial_q <= trial_q + (odd_q ? TRIAL_W'(2) : TRIAL_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pend_div_q <= DIVISOR_W'(1);
      pend_cof_q <= number_masked;
    end else if (cmd_i.found) begin
      pend_div_q <= trial_q[DIVISOR_W-1:0];
      pend_cof_q <= quotient;
    end
  end

  // Output beat: the pending pair leaves when a newer pair replaces it or at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.found || cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.found || cmd_i.flush) begin
      out_div_q  <= pend_div_q;
      out_cof_q  <= pend_cof_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign valid_o    = out_valid_q;
  assign divisor_o  = out_div_q;
  assign cofactor_o = COFACTOR_W'(out_cof_q);
  assign last_o     = out_last_q;

endmodule

FILE: src/dpe_checker.sv
// Port-level checker of the divisor pair enumerator and its bind.
module dpe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            valid_o,
  input logic [dpe_pkg::DIVISOR_W-1:0]   divisor_o,
  input logic                            last_o
);

  // An accepted number makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after accepted beat");

  // The final pair comes out as the block goes idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("last beat while still busy");

  // A non-final pair means more work is in progress
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o)
    else $error("non-last beat while idle");

  // Going idle is always marked by the final pair
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o && last_o)
    else $error("went idle without a last beat");

  // Divisor of a beat is never zero
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> divisor_o != '0)
    else $error("zero divisor on result beat");

endmodule

bind divisor_pair_enumerator dpe_checker u_dpe_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .valid_o   (valid_o),
  .divisor_o (divisor_o),
  .last_o    (last_o)
);

FILE: dv/tb_divisor_pair_enumerator.sv
// Self-checking testbench for the divisor pair enumerator with directed and random numbers.
module tb_divisor_pair_enumerator;
  timeunit 1ns;
  timeprecision 1ps;

  import dpe_pkg::*;

  localparam int unsigned NUMBER_BITS    = 16;
  localparam int unsigned RANDOM_NUMBERS = 118;
  // A 16-bit even number can take long between beats
  localparam int unsigned QUIET_LIMIT    = 40000;
  localparam int unsigned TAIL_CYCLES    = 50;

  typedef struct packed {
    logic [DIVISOR_W-1:0]  divisor;
    logic [COFACTOR_W-1:0] cofactor;
    logic                  last;
  } pair_t;

  // Predicts the divisor pairs of each taken number and matches result beats
  class pair_board #(int unsigned NB = 16);
    localparam int unsigned PAIR_CAP = 60;
    pair_t       expected_pairs[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t ns  mismatch: %s", $time, msg);
    endfunction

    // Trial division, d ascending; odd numbers only try odd d
    function void note_number(logic [NUMBER_W-1:0] raw);
      logic [NUMBER_W-1:0] n;
      logic [TRIAL_W-1:0]  trial;
      logic [TRIAL_W-1:0]  stride;
      pair_t               pair;
      int unsigned         count;
      n = raw & NUMBER_W'((32'd1 << NB) - 32'd1);
      pair.divisor  = DIVISOR_W'(1);
      pair.cofactor = n;
      pair.last     = 1'b0;
      expected_pairs.push_back(pair);
      count  = 1;
      stride = n[0] ? TRIAL_W'(2) : TRIAL_W'(1);
      trial  = n[0] ? TRIAL_W'(3) : TRIAL_W'(2);
      while (32'(trial) * 32'(trial) <= 32'(n) && 32'(trial) <= 32'd255) begin
        if (32'(n) % 32'(trial) == 0 && count < PAIR_CAP) begin
          pair.divisor  = DIVISOR_W'(trial);
          pair.cofactor = COFACTOR_W'(32'(n) / 32'(trial));
          expected_pairs.push_back(pair);
          count++;
        end
        trial = trial + stride;
      end
      // flag the closing pair of this number
      pair = expected_pairs.pop_back();
      pair.last = 1'b1;
      expected_pairs.push_back(pair);
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (expected_pairs.size() == 0) begin
        report($sformatf("beat with nothing pending: d=%0d q=%0d last=%0b",
                         got.divisor, got.cofactor, got.last));
        return;
      end
      want = expected_pairs.pop_front();
      if (got.divisor !== want.divisor)
        report($sformatf("divisor %0d, want %0d", got.divisor, want.divisor));
      if (got.cofactor !== want.cofactor)
        report($sformatf("cofactor %0d, want %0d (d=%0d)", got.cofactor, want.cofactor,
                         want.divisor));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b (d=%0d)", got.last, want.last, want.divisor));
    endfunction
  endclass

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  start_i  = 1'b0;
  logic [NUMBER_W-1:0]   number_i = '0;
  logic                  busy_o;
  logic                  valid_o;
  logic [DIVISOR_W-1:0]  divisor_o;
  logic [COFACTOR_W-1:0] cofactor_o;
  logic                  last_o;

  pair_board #(NUMBER_BITS) board;
  int unsigned quiet_cycles = 0;

  // Edges of the range, squares, highly composite and prime-heavy numbers
  logic [NUMBER_W-1:0] directed_numbers [22] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd36, 16'd49, 16'd225, 16'd256,
    16'd32768, 16'd64516, 16'd65025, 16'd65280, 16'd65498, 16'd65520, 16'd55440,
    16'd65521, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA
  };

  divisor_pair_enumerator #(
    .NUMBER_BITS(NUMBER_BITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .number_i  (number_i),
    .busy_o    (busy_o),
    .valid_o   (valid_o),
    .divisor_o (divisor_o),
    .cofactor_o(cofactor_o),
    .last_o    (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Result beats
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      board.check_pair(pair_t'{divisor_o, cofactor_o, last_o});
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Hold start until the block takes the number
  task automatic send_number(input logic [NUMBER_W-1:0] n);
    start_i  <= 1'b1;
    number_i <= n;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    board.note_number(n);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles == 0) return;
    start_i  <= 1'b0;
    number_i <= NUMBER_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (board.expected_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Small numbers dominate since large even ones take long to enumerate
  function automatic logic [NUMBER_W-1:0] pick_number();
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    roll = $urandom_range(0, 99);
    if (roll < 45) return NUMBER_W'($urandom_range(0, 1023));
    if (roll < 65) return NUMBER_W'($urandom_range(0, 65535));
    if (roll < 77) begin
      a = $urandom_range(0, 255);
      return NUMBER_W'(a * a);
    end
    if (roll < 90) begin
      a = $urandom_range(1, 255);
      b = $urandom_range(1, 65535 / a);
      return NUMBER_W'(a * b);
    end
    a = $urandom_range(0, NUMBER_W - 1);
    if ($urandom_range(0, 1) == 0) return NUMBER_W'(32'd1 << a);
    return ~NUMBER_W'(32'd1 << a);
  endfunction

  initial begin
    bit steady;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed numbers, mostly back to back
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
      pause_sender((i % 3 == 2) ? pick_gap() : 0);
    end
    drain_results();

    // random numbers, with stretches of no sender gaps
    steady = 1'b0;
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      send_number(pick_number());
      if (i == RANDOM_NUMBERS / 2) begin
        drain_results();
      end else begin
        pause_sender(steady ? 0 : pick_gap());
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.expected_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
